// ----- hw/rtl/ukd_pkg.sv -----
// Package for the UDP port knock detector: configuration struct, register
// indexes, queue item struct and the knock port mapping function.
// No dependencies.
package ukd_pkg;

    localparam int unsigned KEY_WORDS = 4;

    localparam logic [2:0] REG_KEY_WORD_0     = 3'd0;
    localparam logic [2:0] REG_KEY_WORD_1     = 3'd1;
    localparam logic [2:0] REG_KEY_WORD_2     = 3'd2;
    localparam logic [2:0] REG_KEY_WORD_3     = 3'd3;
    localparam logic [2:0] REG_INTERVAL_LIMIT = 3'd4;

    localparam logic [31:0] INTERVAL_RESET = 32'd100000;
    localparam logic [15:0] PORT_BASE      = 16'd49152;
    localparam logic [14:0] PORT_MOD       = 15'd16383;

    typedef struct packed {
        logic [KEY_WORDS-1:0][31:0] key_word;
        logic [31:0]                interval_limit;
    } ukd_cfg_t;

    // Classified item as it waits between front and back
    typedef struct packed {
        logic        hit;
        logic [15:0] len;
        logic [31:0] now;
    } ukd_pkt_t;

    // 49152 + h mod 16383; 16384 = 1 (mod 16383), so fold the top two bits in
    function automatic logic [15:0] knock_port(input logic [15:0] h);
        logic [14:0] s;
        begin
            s = {1'b0, h[13:0]} + {13'd0, h[15:14]};
            if (s >= PORT_MOD)
            begin
                s = s - PORT_MOD;
            end
            knock_port = PORT_BASE + {1'b0, s};
        end
    endfunction

endpackage

// ----- hw/rtl/ukd_in_if.sv -----
// Input channel of the knock detector: valid/ready plus packet fields.
// No dependencies.
interface ukd_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] dest_port;
    logic [15:0] packet_length;
    logic [31:0] now_seconds;

    modport source (output valid, output dest_port, output packet_length,
                    output now_seconds, input ready);
    modport sink   (input valid, input dest_port, input packet_length,
                    input now_seconds, output ready);
endinterface

// ----- hw/rtl/ukd_out_if.sv -----
// Result channel of the knock detector: valid/ready plus result fields.
// No dependencies.
interface ukd_out_if;
    logic        valid;
    logic        ready;
    logic        slot_hit;
    logic        knock_opened;
    logic [31:0] last_open_time;

    modport source (output valid, output slot_hit, output knock_opened,
                    output last_open_time, input ready);
    modport sink   (input valid, input slot_hit, input knock_opened,
                    input last_open_time, output ready);
endinterface

// ----- hw/rtl/ukd_regs.sv -----
// APB register file: four key words and the interval limit.
// Depends on ukd_pkg.
module ukd_regs
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ukd_pkg::ukd_cfg_t  cfg
);

    ukd_pkg::ukd_cfg_t cfg_reg;
    ukd_pkg::ukd_cfg_t cfg_next;
    logic [2:0]        idx;
    logic              wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                ukd_pkg::REG_KEY_WORD_0:     cfg_next.key_word[0]    = pwdata;
                ukd_pkg::REG_KEY_WORD_1:     cfg_next.key_word[1]    = pwdata;
                ukd_pkg::REG_KEY_WORD_2:     cfg_next.key_word[2]    = pwdata;
                ukd_pkg::REG_KEY_WORD_3:     cfg_next.key_word[3]    = pwdata;
                ukd_pkg::REG_INTERVAL_LIMIT: cfg_next.interval_limit = pwdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            ukd_pkg::REG_KEY_WORD_0:     prdata = cfg_reg.key_word[0];
            ukd_pkg::REG_KEY_WORD_1:     prdata = cfg_reg.key_word[1];
            ukd_pkg::REG_KEY_WORD_2:     prdata = cfg_reg.key_word[2];
            ukd_pkg::REG_KEY_WORD_3:     prdata = cfg_reg.key_word[3];
            ukd_pkg::REG_INTERVAL_LIMIT: prdata = cfg_reg.interval_limit;
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_word       <= '0;
            cfg_reg.interval_limit <= ukd_pkg::INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/ukd_front.sv -----
// Front end: takes packets and finds the first knock slot whose port matches.
// Depends on ukd_pkg and ukd_in_if.
module ukd_front
#(
    parameter int KNOCK_COUNT = 8,
    parameter int IDX_W       = 3
)
(
    ukd_in_if.sink                 in_ch,
    input  ukd_pkg::ukd_cfg_t      cfg,
    output logic                   push_valid,
    input  logic                   push_ready,
    output ukd_pkg::ukd_pkt_t      push_pkt,
    output logic [IDX_W-1:0]       push_idx
);

    logic [KNOCK_COUNT-1:0][15:0] ports;
    logic [KNOCK_COUNT-1:0]       match;

    always_comb
    begin
        for (int i = 0; i < KNOCK_COUNT; i++)
        begin
            if (i % 2 == 1)
            begin
                ports[i] = ukd_pkg::knock_port(cfg.key_word[i / 2][31:16]);
            end
            else
            begin
                ports[i] = ukd_pkg::knock_port(cfg.key_word[i / 2][15:0]);
            end
            match[i] = (ports[i] == in_ch.dest_port);
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        push_idx = '0;
        for (int i = KNOCK_COUNT - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                push_idx = IDX_W'(i);
            end
        end
    end

    assign push_pkt.hit = |match;
    assign push_pkt.len = in_ch.packet_length;
    assign push_pkt.now = in_ch.now_seconds;
    assign push_valid   = in_ch.valid;
    assign in_ch.ready  = push_ready;

endmodule

// ----- hw/rtl/ukd_queue.sv -----
// Short FIFO between front and back end.
// No dependencies.
module ukd_queue
#(
    parameter int WIDTH = 53,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/ukd_back.sv -----
// Back end: records the knock, tests the pattern and registers the result.
// Depends on ukd_pkg and ukd_out_if.
module ukd_back
#(
    parameter int KNOCK_COUNT = 8,
    parameter int IDX_W       = 3
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  ukd_pkg::ukd_cfg_t  cfg,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  ukd_pkg::ukd_pkt_t  pop_pkt,
    input  logic [IDX_W-1:0]   pop_idx,
    ukd_out_if.source          out_ch
);

    logic [31:0] slot_time_reg [KNOCK_COUNT];
    logic [31:0] slot_time_next [KNOCK_COUNT];
    logic [15:0] slot_len_reg [KNOCK_COUNT];
    logic [15:0] slot_len_next [KNOCK_COUNT];
    logic [31:0] upd_time [KNOCK_COUNT];
    logic [15:0] upd_len [KNOCK_COUNT];
    logic [31:0] open_time_reg, open_time_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_hit_reg, out_hit_next;
    logic        out_opened_reg, out_opened_next;
    logic        pass;
    logic        do_pop;

    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        pass = 1'b1;
        for (int i = 0; i < KNOCK_COUNT; i++)
        begin
            if (pop_pkt.hit && (pop_idx == IDX_W'(i)))
            begin
                upd_time[i] = pop_pkt.now;
                upd_len[i]  = pop_pkt.len;
            end
            else
            begin
                upd_time[i] = slot_time_reg[i];
                upd_len[i]  = slot_len_reg[i];
            end
        end
        // modular age; a slot time ahead of now gives a huge age
        for (int i = 0; i < KNOCK_COUNT; i++)
        begin
            if ((pop_pkt.now - upd_time[i]) > cfg.interval_limit)
            begin
                pass = 1'b0;
            end
        end
        for (int i = 0; i < KNOCK_COUNT - 1; i++)
        begin
            if (upd_len[i] >= upd_len[i + 1])
            begin
                pass = 1'b0;
            end
        end
    end

    always_comb
    begin
        open_time_next  = open_time_reg;
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        out_opened_next = out_opened_reg;
        for (int i = 0; i < KNOCK_COUNT; i++)
        begin
            slot_time_next[i] = slot_time_reg[i];
            slot_len_next[i]  = slot_len_reg[i];
        end
        if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (do_pop)
        begin
            out_valid_next  = 1'b1;
            out_hit_next    = pop_pkt.hit;
            out_opened_next = pass;
            if (pass)
            begin
                open_time_next = pop_pkt.now;
            end
            for (int i = 0; i < KNOCK_COUNT; i++)
            begin
                slot_time_next[i] = pass ? 32'd0 : upd_time[i];
                slot_len_next[i]  = pass ? 16'd0 : upd_len[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_time_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_opened_reg <= 1'b0;
            for (int i = 0; i < KNOCK_COUNT; i++)
            begin
                slot_time_reg[i] <= '0;
                slot_len_reg[i]  <= '0;
            end
        end
        else
        begin
            open_time_reg  <= open_time_next;
            out_valid_reg  <= out_valid_next;
            out_hit_reg    <= out_hit_next;
            out_opened_reg <= out_opened_next;
            for (int i = 0; i < KNOCK_COUNT; i++)
            begin
                slot_time_reg[i] <= slot_time_next[i];
                slot_len_reg[i]  <= slot_len_next[i];
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.slot_hit       = out_hit_reg;
    assign out_ch.knock_opened   = out_opened_reg;
    assign out_ch.last_open_time = open_time_reg;

endmodule

// ----- hw/rtl/udp_port_knock_detector.sv -----
// UDP port knock detector, top level.
// The accepted item is registered in the queue; the back end loads the result register
// when it takes the item from the queue, and the result is then offered on out_ch.
// Throughput: one item per cycle unless out_ch stalls; the back end's slot update and
// pattern test are combinational, and a two-entry queue absorbs a stalled result channel.
// Reset (rst_n, async, active low) clears slots, open time, queue and key words;
// interval limit resets to 100000.
module udp_port_knock_detector
#(
    parameter int KNOCK_COUNT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    ukd_in_if.sink      in_ch,
    ukd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W   = $clog2(KNOCK_COUNT);
    localparam int PKT_W   = $bits(ukd_pkg::ukd_pkt_t);
    localparam int ENTRY_W = PKT_W + IDX_W;

    ukd_pkg::ukd_cfg_t cfg;
    ukd_pkg::ukd_pkt_t push_pkt, pop_pkt;
    logic [IDX_W-1:0]  push_idx, pop_idx;
    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    logic [ENTRY_W-1:0] pop_data;

    ukd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ukd_front #(.KNOCK_COUNT(KNOCK_COUNT), .IDX_W(IDX_W)) u_front
    (
        .in_ch      (in_ch),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_pkt   (push_pkt),
        .push_idx   (push_idx)
    );

    ukd_queue #(.WIDTH(ENTRY_W), .DEPTH(2)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({push_pkt, push_idx}),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    assign pop_pkt = pop_data[ENTRY_W-1:IDX_W];
    assign pop_idx = pop_data[IDX_W-1:0];

    ukd_back #(.KNOCK_COUNT(KNOCK_COUNT), .IDX_W(IDX_W)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_pkt   (pop_pkt),
        .pop_idx   (pop_idx),
        .out_ch    (out_ch)
    );

endmodule

// ----- hw/rtl/ukd_checker.sv -----
// Port-level checks for the knock detector, bound to the top level.
// Depends on udp_port_knock_detector.
module ukd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        slot_hit,
    input logic        knock_opened,
    input logic [31:0] last_open_time,
    input logic        pready
);

    logic out_fire;

    assign out_fire = out_valid && out_ready;

    // checked once the reset branch has run
    a_no_result_in_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

    a_open_time_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && knock_opened) ##1 (out_fire && !knock_opened)
        |-> last_open_time == $past(last_open_time))
        else $error("open time moved without an opening");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result withdrawn while stalled");

    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(slot_hit) && $stable(knock_opened)
        && $stable(last_open_time)))
        else $error("result changed while stalled");

endmodule

bind udp_port_knock_detector ukd_checker u_ukd_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .slot_hit       (out_ch.slot_hit),
    .knock_opened   (out_ch.knock_opened),
    .last_open_time (out_ch.last_open_time),
    .pready         (pready)
);
